/* rtl/wcp_pkg.sv */
package wcp_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int ROWS        = (MAX_COLUMNS + LANES - 1) / LANES;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DIV_STEPS   = 16;
  localparam int DIV_CNT_W   = 4;

  localparam logic [6:0]  MAX_COLS7 = 7'(MAX_COLUMNS);
  localparam logic [23:0] SAT24     = 24'hFFFFFF;

  typedef enum logic [2:0] {
    REG_FIXED_COLUMNS,
    REG_COLUMN_WIDTH,
    REG_GAP_HORIZONTAL,
    REG_GAP_VERTICAL,
    REG_MARGIN_HORIZONTAL,
    REG_MARGIN_VERTICAL,
    REG_ALIGN_MODE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALIGN_NONE,
    ALIGN_LEFT,
    ALIGN_CENTER,
    ALIGN_RIGHT
  } align_t;

  typedef enum logic {
    REQ_START,
    REQ_PLACE
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DIVIDE,
    ST_PRODUCT,
    ST_ORIGIN,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [6:0]  fixed_columns;
    logic [14:0] column_width;
    logic [11:0] gap_horizontal;
    logic [11:0] gap_vertical;
    logic [11:0] margin_horizontal;
    logic [11:0] margin_vertical;
    align_t      align_mode;
  } cfg_t;

  typedef struct packed {
    req_t        req;
    logic [14:0] area_left;
    logic [14:0] area_width;
    logic [14:0] item_height;
  } cmd_t;

  typedef struct packed {
    logic signed [24:0] item_left;
    logic [23:0]        item_top;
    logic [5:0]         column_index;
    logic [6:0]         columns_in_use;
    logic [23:0]        content_height;
  } res_t;

endpackage

/* rtl/wcp_front.sv */
module wcp_front import wcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [14:0] area_left,
  input  logic [14:0] area_width,
  input  logic [14:0] item_height,
  output cmd_t        cmd,
  output logic        cmd_valid,
  input  logic        cmd_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       incoming;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // classify the item on the way in
  always_comb begin
    incoming.req         = req_t'(req_type);
    incoming.area_left   = area_left;
    incoming.area_width  = area_width;
    incoming.item_height = item_height;
    if (incoming.req == REQ_PLACE) begin
      incoming.area_left  = '0;
      incoming.area_width = '0;
    end else begin
      incoming.item_height = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

/* rtl/wcp_back.sv */
module wcp_back import wcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_pop,
  output res_t res,
  output logic res_push,
  input  logic res_full
);

  back_state_t state;
  back_state_t state_next;

  cmd_t               cur;
  logic [6:0]         active;
  logic signed [24:0] origin;
  logic [23:0]        tallest;
  logic [23:0]        bottoms [ROWS][LANES];

  logic [16:0]          rem;
  logic [15:0]          dvd;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [22:0]          prod;
  logic signed [25:0]   pre2;
  logic signed [25:0]   pre3;
  logic [ROW_W-1:0]     row;
  logic [23:0]          best;
  logic [5:0]           best_idx;
  logic signed [24:0]   res_left;
  logic [23:0]          res_top;
  logic [5:0]           res_col;

  logic [15:0]        pitch;
  logic signed [16:0] num;
  logic               need_div;
  logic [6:0]         count_now;
  logic [16:0]        rem_sh;
  logic               q_bit;
  logic [16:0]        rem_next;
  logic [15:0]        dvd_next;
  logic signed [25:0] diff;
  logic signed [25:0] half;
  logic signed [25:0] origin_full;
  logic [23:0]        scan_best;
  logic [5:0]         scan_idx;
  logic [6:0]         col7;
  logic               scan_done;
  logic [25:0]        grow_sum;
  logic [23:0]        new_bottom;
  logic [21:0]        col_offset;
  logic [24:0]        content_sum;

  function automatic logic [6:0] clamp_cols(input logic [15:0] v);
    logic [6:0] r;
    if (v == 16'd0) begin
      r = 7'd1;
    end else if (v > 16'(MAX_COLS7)) begin
      r = MAX_COLS7;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  assign pitch = 16'(cfg.column_width) + 16'(cfg.gap_horizontal);
  assign num   = $signed({2'b00, cur.area_width})
               - $signed({4'b0000, cfg.margin_horizontal, 1'b0})
               + $signed({5'b00000, cfg.gap_horizontal});

  always_comb begin
    need_div  = 1'b0;
    count_now = 7'd1;
    if (cfg.fixed_columns != 7'd0) begin
      count_now = clamp_cols(16'(cfg.fixed_columns));
    end else if (pitch == 16'd0) begin
      count_now = MAX_COLS7;
    end else if (num[16] || num == 17'sd0) begin
      count_now = 7'd1;
    end else begin
      need_div = 1'b1;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh   = {rem[15:0], dvd[15]};
  assign q_bit    = (rem_sh >= {1'b0, pitch});
  assign rem_next = q_bit ? (rem_sh - {1'b0, pitch}) : rem_sh;
  assign dvd_next = {dvd[14:0], q_bit};

  // origin from alignment, centre division truncates toward zero
  always_comb begin
    diff = $signed({11'd0, cur.area_width}) - $signed({3'd0, prod});
    half = (diff + $signed({25'd0, diff[25]})) >>> 1;
    unique case (cfg.align_mode)
      ALIGN_LEFT:   origin_full = $signed({11'd0, cur.area_left})
                                + $signed({14'd0, cfg.margin_horizontal});
      ALIGN_CENTER: origin_full = pre2 + half;
      ALIGN_RIGHT:  origin_full = pre3 - $signed({3'd0, prod});
      default:      origin_full = $signed({14'd0, cfg.margin_horizontal});
    endcase
  end

  // four columns per cycle, leftmost wins ties
  always_comb begin
    scan_best = best;
    scan_idx  = best_idx;
    col7      = '0;
    for (int k = 0; k < LANES; k++) begin
      col7 = (7'(row) << LANE_W) | 7'(k);
      if (col7 < active && bottoms[row][k] < scan_best) begin
        scan_best = bottoms[row][k];
        scan_idx  = col7[5:0];
      end
    end
  end

  assign scan_done = (((7'(row) + 7'd1) << LANE_W) >= active);

  assign grow_sum   = 26'(best) + 26'(cur.item_height) + 26'(cfg.gap_vertical);
  assign new_bottom = (grow_sum > 26'(SAT24)) ? SAT24 : grow_sum[23:0];
  assign col_offset = 22'(best_idx) * 22'(pitch);

  assign content_sum = 25'(tallest) + 25'(cfg.margin_vertical);

  always_comb begin
    res.item_left      = res_left;
    res.item_top       = res_top;
    res.column_index   = res_col;
    res.columns_in_use = active;
    res.content_height = (content_sum > 25'(SAT24)) ? SAT24 : content_sum[23:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.req == REQ_START) ? ST_COUNT : ST_SCAN;
        end
      end
      ST_COUNT:   state_next = need_div ? ST_DIVIDE : ST_PRODUCT;
      ST_DIVIDE: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_PRODUCT;
        end
      end
      ST_PRODUCT: state_next = ST_ORIGIN;
      ST_ORIGIN:  state_next = ST_EMIT;
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = (state == ST_IDLE) && cmd_valid;
    res_push = (state == ST_EMIT) && !res_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      active  <= 7'd1;
      origin  <= '0;
      tallest <= '0;
      for (int r = 0; r < ROWS; r++) begin
        for (int k = 0; k < LANES; k++) begin
          bottoms[r][k] <= '0;
        end
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_COUNT: begin
          if (!need_div) begin
            active <= count_now;
          end
        end
        ST_DIVIDE: begin
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            active <= clamp_cols(dvd_next);
          end
        end
        ST_ORIGIN: begin
          origin  <= origin_full[24:0];
          tallest <= 24'(cfg.margin_vertical);
          for (int r = 0; r < ROWS; r++) begin
            for (int k = 0; k < LANES; k++) begin
              bottoms[r][k] <= 24'(cfg.margin_vertical);
            end
          end
        end
        ST_UPDATE: begin
          bottoms[best_idx[LANE_W +: ROW_W]][best_idx[LANE_W-1:0]] <= new_bottom;
          if (new_bottom > tallest) begin
            tallest <= new_bottom;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur      <= cmd;
        row      <= '0;
        best     <= SAT24;
        best_idx <= '0;
      end
      ST_COUNT: begin
        rem     <= '0;
        dvd     <= num[15:0];
        div_cnt <= '0;
      end
      ST_DIVIDE: begin
        rem     <= rem_next;
        dvd     <= dvd_next;
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      ST_PRODUCT: begin
        prod <= 23'(active) * 23'(pitch);
        pre2 <= $signed({11'd0, cur.area_left}) + $signed({15'd0, cfg.gap_horizontal[11:1]});
        pre3 <= $signed({11'd0, cur.area_left}) + $signed({11'd0, cur.area_width})
              - 26'sd1 - $signed({14'd0, cfg.margin_horizontal})
              + $signed({14'd0, cfg.gap_horizontal});
      end
      ST_ORIGIN: begin
        res_left <= origin_full[24:0];
        res_top  <= '0;
        res_col  <= '0;
      end
      ST_SCAN: begin
        best     <= scan_best;
        best_idx <= scan_idx;
        row      <= row + ROW_W'(1);
      end
      ST_UPDATE: begin
        res_left <= origin + $signed({3'd0, col_offset});
        res_top  <= best;
        res_col  <= best_idx;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/wcp_result_q.sv */
module wcp_result_q import wcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  res_t res_in,
  input  logic res_push,
  output logic res_full,
  output res_t res_out,
  output logic empty,
  input  logic pop
);

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = slots[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res_in;
    end
  end

endmodule

/* rtl/waterfall_column_placer_top.sv */
// Masonry column placer. A start item (req_type 0) sets the column count and
// left origin of a new layout and answers with the origin; a place item
// (req_type 1) drops one item into the lowest column, leftmost on ties, and
// answers with its position. Every item gives exactly one result. Items enter
// through a two-deep queue and results leave through a two-deep queue, so
// both sides may stall freely. A place item runs the column scan, which
// compares four column bottoms per cycle, and then updates the lowest
// column. A start item divides the column count out of the area width with
// the 16-step restoring divider, unless the count is fixed, the column pitch
// is zero or the width less both margins plus one gap is not positive.
// Configuration writes are meant for times when both queues are empty and
// the block is idle.
module waterfall_column_placer_top import wcp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               req_type,
  input  logic [14:0]        area_left,
  input  logic [14:0]        area_width,
  input  logic [14:0]        item_height,
  output logic               empty,
  input  logic               pop,
  output logic signed [24:0] item_left,
  output logic [23:0]        item_top,
  output logic [5:0]         column_index,
  output logic [6:0]         columns_in_use,
  output logic [23:0]        content_height,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_addr,
  input  logic [14:0]        cfg_wdata
);

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res_back;
  logic res_push;
  logic res_full;
  res_t res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_columns     <= 7'd0;
      cfg.column_width      <= 15'd1;
      cfg.gap_horizontal    <= 12'd0;
      cfg.gap_vertical      <= 12'd0;
      cfg.margin_horizontal <= 12'd0;
      cfg.margin_vertical   <= 12'd0;
      cfg.align_mode        <= ALIGN_LEFT;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FIXED_COLUMNS:     cfg.fixed_columns     <= cfg_wdata[6:0];
        REG_COLUMN_WIDTH:      cfg.column_width      <= cfg_wdata;
        REG_GAP_HORIZONTAL:    cfg.gap_horizontal    <= cfg_wdata[11:0];
        REG_GAP_VERTICAL:      cfg.gap_vertical      <= cfg_wdata[11:0];
        REG_MARGIN_HORIZONTAL: cfg.margin_horizontal <= cfg_wdata[11:0];
        REG_MARGIN_VERTICAL:   cfg.margin_vertical   <= cfg_wdata[11:0];
        REG_ALIGN_MODE:        cfg.align_mode        <= align_t'(cfg_wdata[1:0]);
        default: begin
        end
      endcase
    end
  end

  wcp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .area_left   (area_left),
    .area_width  (area_width),
    .item_height (item_height),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop)
  );

  wcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res       (res_back),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  wcp_result_q u_result_q (
    .clk      (clk),
    .rst      (rst),
    .res_in   (res_back),
    .res_push (res_push),
    .res_full (res_full),
    .res_out  (res_out),
    .empty    (empty),
    .pop      (pop)
  );

  assign item_left      = res_out.item_left;
  assign item_top       = res_out.item_top;
  assign column_index   = res_out.column_index;
  assign columns_in_use = res_out.columns_in_use;
  assign content_height = res_out.content_height;

endmodule

/* tb/waterfall_column_placer_top_tb.sv */
`timescale 1ns / 1ps

module waterfall_column_placer_top_tb;
  import wcp_pkg::*;

  localparam int HOLD_PHASE  = 8;
  localparam int HOLD_CYCLES = 300;

  logic               clk;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               req_type = 1'b0;
  logic [14:0]        area_left = '0;
  logic [14:0]        area_width = '0;
  logic [14:0]        item_height = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [24:0] item_left;
  logic [23:0]        item_top;
  logic [5:0]         column_index;
  logic [6:0]         columns_in_use;
  logic [23:0]        content_height;
  logic               cfg_write_en = 1'b0;
  logic [2:0]         cfg_addr = '0;
  logic [14:0]        cfg_wdata = '0;

  waterfall_column_placer_top i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .req_type(req_type),
    .area_left(area_left),
    .area_width(area_width),
    .item_height(item_height),
    .empty(empty),
    .pop(pop),
    .item_left(item_left),
    .item_top(item_top),
    .column_index(column_index),
    .columns_in_use(columns_in_use),
    .content_height(content_height),
    .cfg_write_en(cfg_write_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // layout registers as the block should hold them
  logic [6:0]  cf_fixed = 7'd0;
  logic [14:0] cf_col_width = 15'd1;
  logic [11:0] cf_gap_h = '0;
  logic [11:0] cf_gap_v = '0;
  logic [11:0] cf_margin_h = '0;
  logic [11:0] cf_margin_v = '0;
  align_t      cf_align = ALIGN_LEFT;

  // layout state
  logic [23:0] col_bottom [MAX_COLUMNS] = '{default: 24'd0};
  int          n_active = 1;
  longint      origin = 0;
  logic [23:0] tallest = '0;

  cmd_t        requests_pending [$];
  cmd_t        on_bus;
  res_t        placements_due [$];
  res_t        want_r;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        rx_blocked = 1'b0;
  int          phase_no = 0;
  int          mismatches = 0;
  int          results_checked = 0;
  int          starts_accepted = 0;
  int          places_accepted = 0;
  int          layouts_set = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [23:0] sat24(longint v);
    return (v > longint'(SAT24)) ? SAT24 : 24'(v);
  endfunction

  function automatic void layout_step(cmd_t c);
    longint      pitch, n, pos, al, aw, gh, mh;
    logic [23:0] top;
    int          idx;
    res_t        r;
    al = c.area_left;
    aw = c.area_width;
    gh = cf_gap_h;
    mh = cf_margin_h;
    pitch = longint'(cf_col_width) + gh;
    r = '0;
    if (c.req == REQ_START) begin
      starts_accepted++;
      if (cf_fixed != 0) n = cf_fixed;
      else if (pitch == 0) n = MAX_COLUMNS;
      else n = (aw - 2 * mh + gh) / pitch;
      if (n < 1) n = 1;
      if (n > MAX_COLUMNS) n = MAX_COLUMNS;
      n_active = int'(n);
      case (cf_align)
        ALIGN_LEFT:   origin = al + mh;
        ALIGN_CENTER: origin = al + (aw - n * pitch) / 2 + gh / 2;
        ALIGN_RIGHT:  origin = al + aw - 1 - mh - n * pitch + gh;
        default:      origin = mh;
      endcase
      foreach (col_bottom[i]) col_bottom[i] = 24'(cf_margin_v);
      tallest = 24'(cf_margin_v);
      r.item_left = 25'(origin);
    end else begin
      places_accepted++;
      idx = 0;
      top = col_bottom[0];
      // lowest column wins, leftmost on ties
      for (int i = 1; i < n_active; i++) begin
        if (col_bottom[i] < top) begin
          idx = i;
          top = col_bottom[i];
        end
      end
      pos = origin + longint'(idx) * pitch;
      col_bottom[idx] = sat24(longint'(top) + longint'(c.item_height) + longint'(cf_gap_v));
      if (col_bottom[idx] > tallest) tallest = col_bottom[idx];
      r.item_left = 25'(pos);
      r.item_top = top;
      r.column_index = 6'(idx);
    end
    r.columns_in_use = 7'(n_active);
    r.content_height = sat24(longint'(tallest) + longint'(cf_margin_v));
    placements_due.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) layout_step(on_bus);
      if (!(push && full)) begin
        if (requests_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_bus = requests_pending.pop_front();
          push <= 1'b1;
          req_type <= on_bus.req;
          area_left <= on_bus.area_left;
          area_width <= on_bus.area_width;
          item_height <= on_bus.item_height;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s of result %0d: expected %0h, got %0h",
                 name, results_checked, want, got);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (placements_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no item waiting for it: left %0h top %0h column %0d",
                     item_left, item_top, column_index);
        end else begin
          want_r = placements_due.pop_front();
          check_field("item_left", want_r.item_left, item_left);
          check_field("item_top", want_r.item_top, item_top);
          check_field("column_index", want_r.column_index, column_index);
          check_field("columns_in_use", want_r.columns_in_use, columns_in_use);
          check_field("content_height", want_r.content_height, content_height);
          results_checked++;
        end
      end
      pop <= !rx_blocked && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(cfg_reg_t idx, int val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= 15'(val);
    case (idx)
      REG_FIXED_COLUMNS:     cf_fixed = 7'(val);
      REG_COLUMN_WIDTH:      cf_col_width = 15'(val);
      REG_GAP_HORIZONTAL:    cf_gap_h = 12'(val);
      REG_GAP_VERTICAL:      cf_gap_v = 12'(val);
      REG_MARGIN_HORIZONTAL: cf_margin_h = 12'(val);
      REG_MARGIN_VERTICAL:   cf_margin_v = 12'(val);
      REG_ALIGN_MODE:        cf_align = align_t'(val[1:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_config(int fixed, int cw, int gh, int gv, int mh, int mv, align_t al);
    write_reg(REG_FIXED_COLUMNS, fixed);
    write_reg(REG_COLUMN_WIDTH, cw);
    write_reg(REG_GAP_HORIZONTAL, gh);
    write_reg(REG_GAP_VERTICAL, gv);
    write_reg(REG_MARGIN_HORIZONTAL, mh);
    write_reg(REG_MARGIN_VERTICAL, mv);
    write_reg(REG_ALIGN_MODE, int'(al));
    layouts_set++;
  endtask

  task automatic random_config();
    int fixed, cw;
    case ($urandom_range(5))
      0:       fixed = $urandom_range(16, 1);
      1:       fixed = $urandom_range(127, 17);
      default: fixed = 0;
    endcase
    case ($urandom_range(5))
      0:       cw = $urandom_range(100, 1);
      1:       cw = $urandom_range(3000, 100);
      2:       cw = $urandom_range(32767, 1000);
      3:       cw = 32767;
      4:       cw = 0;
      default: cw = $urandom_range(600, 20);
    endcase
    set_config(fixed, cw,
               $urandom_range(1) ? $urandom_range(64) : $urandom_range(4095),
               $urandom_range(4095),
               $urandom_range(1) ? $urandom_range(64) : $urandom_range(4095),
               $urandom_range(4095),
               align_t'($urandom_range(3)));
  endtask

  task automatic add_item(req_t r, int left, int width, int h);
    cmd_t c;
    c.req = r;
    c.area_left = 15'(left);
    c.area_width = 15'(width);
    c.item_height = 15'(h);
    requests_pending.push_back(c);
  endtask

  // mostly a start followed by a run of placements, some loose noise items
  task automatic random_phase(int count);
    int added, runs;
    added = 0;
    while (added < count) begin
      if ($urandom_range(9) < 8) begin
        add_item(REQ_START, $urandom_range(32767),
                 $urandom_range(1) ? $urandom_range(32767) : $urandom_range(2000),
                 $urandom_range(32767));
        runs = $urandom_range(30, 1);
        repeat (runs)
          add_item(REQ_PLACE, $urandom_range(32767), $urandom_range(32767),
                   $urandom_range(1) ? $urandom_range(32767) : $urandom_range(64));
        added += runs + 1;
      end else begin
        add_item(req_t'($urandom_range(1)), $urandom, $urandom, $urandom);
        added++;
      end
    end
  endtask

  task automatic run_phase();
    if (phase_no < 7) begin
      tx_idle_pct <= 34;
      rx_idle_pct <= 54;
    end else if (phase_no < 11) begin
      tx_idle_pct <= 54;
      rx_idle_pct <= 34;
    end else begin
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
    end
    if (phase_no == HOLD_PHASE) begin
      // receiver holds off so the block backs up and stalls its input
      @(posedge clk);
      rx_blocked <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_blocked <= 1'b0;
    end
    // sampled away from the active edge so driver updates have settled
    while (requests_pending.size() != 0 || push || placements_due.size() != 0)
      @(negedge clk);
    phase_no++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, placements before any start
    add_item(REQ_PLACE, 0, 0, 5);
    add_item(REQ_PLACE, 32767, 32767, 32767);
    add_item(REQ_START, 32767, 32767, 0);
    add_item(REQ_START, 0, 0, 32767);
    add_item(REQ_START, 0, 9, 0);
    add_item(REQ_PLACE, 0, 0, 0);
    add_item(REQ_PLACE, 0, 0, 32767);
    add_item(REQ_PLACE, 0, 0, 100);
    run_phase();

    // zero pitch
    set_config(0, 0, 0, 4095, 4095, 4095, ALIGN_CENTER);
    add_item(REQ_START, 1000, 1, 0);
    add_item(REQ_PLACE, 0, 0, 7);
    add_item(REQ_PLACE, 0, 0, 0);
    run_phase();

    // negative count numerator, right alignment below zero
    set_config(0, 32767, 4095, 0, 4095, 0, ALIGN_RIGHT);
    add_item(REQ_START, 12345, 10, 0);
    add_item(REQ_PLACE, 0, 0, 32767);
    add_item(REQ_START, 0, 32767, 0);
    run_phase();

    // fixed count above the limit, ties
    set_config(127, 1, 4095, 4095, 0, 0, ALIGN_NONE);
    add_item(REQ_START, 32767, 32767, 0);
    add_item(REQ_PLACE, 0, 0, 0);
    add_item(REQ_PLACE, 0, 0, 0);
    add_item(REQ_PLACE, 0, 0, 0);
    run_phase();

    // centre with odd negative offset
    set_config(16, 1000, 10, 1, 0, 0, ALIGN_CENTER);
    add_item(REQ_START, 5, 101, 0);
    add_item(REQ_PLACE, 0, 0, 1);
    add_item(REQ_PLACE, 0, 0, 1);
    run_phase();

    repeat (2) begin
      random_config();
      random_phase(62);
      run_phase();
    end

    // single column driven into saturation
    set_config(1, $urandom_range(32767, 1), $urandom_range(4095), 4095,
               $urandom_range(4095), 4095, align_t'($urandom_range(3)));
    add_item(REQ_START, $urandom_range(32767), $urandom_range(32767), 0);
    repeat (470)
      add_item(REQ_PLACE, $urandom_range(32767), $urandom_range(32767),
               32767 - $urandom_range(15));
    run_phase();

    repeat (7) begin
      random_config();
      random_phase(62);
      run_phase();
    end

    repeat (30) @(posedge clk);
    $display("covered %0d items (%0d layout starts, %0d placements) over %0d layouts",
             starts_accepted + places_accepted, starts_accepted, places_accepted,
             layouts_set + 1);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still due", placements_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/wcp_pkg.sv
rtl/wcp_front.sv
rtl/wcp_back.sv
rtl/wcp_result_q.sv
rtl/waterfall_column_placer_top.sv
tb/waterfall_column_placer_top_tb.sv
